@@ rtl/asd_pkg.sv @@
`default_nettype none

package asd_pkg;

   localparam int PAT_MAX_DEFAULT = 32;

   localparam int OP_W   = 2;
   localparam int SYM_W  = 8;
   localparam int DIST_W = 6;

   localparam logic [OP_W-1:0] OP_NEW_PATTERN = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND      = 2'd1;
   localparam logic [OP_W-1:0] OP_TEXT        = 2'd2;
   localparam logic [OP_W-1:0] OP_FINISH      = 2'd3;

   localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

   // control carried between neighboring cells
   typedef struct packed {
      logic             valid;
      logic             has_last;
      logic [SYM_W-1:0] sym;
   } link_ctl_type;

endpackage

`default_nettype wire

@@ rtl/asd_req_if.sv @@
`default_nettype none

interface asd_req_if
   import asd_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  opcode;
   logic [SYM_W-1:0] symbol;

   modport source (output valid, output opcode, output symbol, input ready);
   modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

`default_nettype wire

@@ rtl/asd_rsp_if.sv @@
`default_nettype none

interface asd_rsp_if
   import asd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              pattern_overflow;

   modport source (output valid, output distance, output pattern_overflow, input ready);
   modport sink   (input valid, input distance, input pattern_overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/asd_cell.sv @@
`default_nettype none

module asd_cell
   import asd_pkg::*;
#(
   parameter int ROW = 0,
   parameter int VW  = 6
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         clear,
   input  wire logic         active,
   input  wire logic         is_last,
   input  wire logic         wr_en,
   input  wire logic [SYM_W-1:0] wr_sym,
   input  wire link_ctl_type ctl_in,
   input  wire logic [VW-1:0] above_in,
   input  wire logic [VW-1:0] diag_in,
   input  wire logic [VW-1:0] last_in,
   output link_ctl_type      ctl_out,
   output logic [VW-1:0]     above_out,
   output logic [VW-1:0]     diag_out,
   output logic [VW-1:0]     last_out
);

   localparam logic [VW-1:0] ROW_INIT = VW'(ROW + 1);

   logic [SYM_W-1:0] pat_ff;
   logic [VW-1:0]    col_ff, col_in;
   link_ctl_type     fwd_ff, fwd_in;
   logic [VW-1:0]    above_ff, diag_ff, tail_ff, tail_in;

   logic [VW:0] sub_c, ins_c, mat_c, m_ab, m_all;
   logic [VW-1:0] v;

   always_comb begin
      sub_c = {1'b0, col_ff} + (VW+1)'(1);
      ins_c = {1'b0, above_in} + (VW+1)'(1);
      mat_c = {1'b0, diag_in} + (VW+1)'(pat_ff != ctl_in.sym);
      m_ab  = (sub_c < ins_c) ? sub_c : ins_c;
      m_all = (m_ab < mat_c) ? m_ab : mat_c;
      v     = m_all[VW-1:0];
   end

   always_comb begin
      col_in = col_ff;
      if (clear) begin
         col_in = ROW_INIT;
      end else if (ctl_in.valid && active) begin
         col_in = v;
      end
      fwd_in          = ctl_in;
      fwd_in.has_last = ctl_in.has_last | (is_last & active);
      tail_in         = (is_last && active) ? v : last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= ROW_INIT;
         fwd_ff <= '0;
      end else begin
         col_ff <= col_in;
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_ff <= wr_sym;
      end
      above_ff <= v;
      diag_ff  <= col_ff;
      tail_ff  <= tail_in;
   end

   assign ctl_out   = fwd_ff;
   assign above_out = above_ff;
   assign diag_out  = diag_ff;
   assign last_out  = tail_ff;

endmodule

`default_nettype wire

@@ rtl/approximate_substring_distance.sv @@
`default_nettype none
// Latency: a finish result is registered and valid the cycle after the finish item is accepted.
// Throughput: text items are taken one per cycle; each sweeps the row of PAT_MAX cells, one
// cell per cycle. New-pattern, append and finish items stall after the last text item is
// accepted, until it leaves the row; they also wait for a free result slot.
// Reset (synchronous, active high): pattern length, best distance and flags clear and the
// column reloads its initial values at once; pattern bytes keep whatever they hold until appended.

module approximate_substring_distance
   import asd_pkg::*;
#(
   parameter int PAT_MAX = PAT_MAX_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   asd_req_if.sink   req_chan,
   asd_rsp_if.source rsp_chan
);

   // pattern length and DP values both range over 0..PAT_MAX
   localparam int LW = $clog2(PAT_MAX + 1);
   localparam int VW = LW;
   localparam int EW = (VW > DIST_W) ? VW : DIST_W;

   // state
   logic [LW-1:0]     len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic              seen_ff, seen_in;
   logic [VW-1:0]     best_ff, best_in;
   logic [LW-1:0]     drain_ff, drain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] dist_ff;
   logic              rsp_ovf_ff;

   // item decode
   logic is_text, accept, clear_col, append_ok, finish;
   logic [EW-1:0]     best_ext;
   logic [DIST_W-1:0] dist_sat, dist_res;

   // the cell row
   link_ctl_type  link  [PAT_MAX:0];
   logic [VW-1:0] above [PAT_MAX:0];
   logic [VW-1:0] diag  [PAT_MAX:0];
   logic [VW-1:0] last  [PAT_MAX:0];

   // text streams freely; everything else waits for an empty row and a free result slot
   assign is_text = (req_chan.opcode == OP_TEXT);
   assign req_chan.ready = is_text ||
                           ((drain_ff == '0) && (!rsp_valid_ff || rsp_chan.ready));
   assign accept    = req_chan.valid && req_chan.ready;
   assign finish    = accept && (req_chan.opcode == OP_FINISH);
   assign clear_col = accept && ((req_chan.opcode == OP_NEW_PATTERN) ||
                                 (req_chan.opcode == OP_FINISH));
   assign append_ok = accept && (req_chan.opcode == OP_APPEND) &&
                      (len_ff != LW'(PAT_MAX));

   // feed the head of the row: row 0 of the DP column is always zero
   always_comb begin
      link[0].valid    = accept && is_text;
      link[0].has_last = 1'b0;
      link[0].sym      = req_chan.symbol;
      above[0]         = '0;
      diag[0]          = '0;
      last[0]          = '0;
   end

   // one cell per pattern row; each cell registers the wavefront before passing it on
   for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
      asd_cell #(
         .ROW (k),
         .VW  (VW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (clear_col),
         .active    (len_ff > LW'(k)),
         .is_last   (len_ff == LW'(k + 1)),
         .wr_en     (append_ok && (len_ff == LW'(k))),
         .wr_sym    (req_chan.symbol),
         .ctl_in    (link[k]),
         .above_in  (above[k]),
         .diag_in   (diag[k]),
         .last_in   (last[k]),
         .ctl_out   (link[k+1]),
         .above_out (above[k+1]),
         .diag_out  (diag[k+1]),
         .last_out  (last[k+1])
      );
   end

   // saturate the running minimum into the result field, or give zero with an empty pattern or no text
   always_comb begin
      best_ext = EW'(best_ff);
      dist_sat = (best_ext > EW'(DIST_MAX)) ? DIST_MAX : best_ext[DIST_W-1:0];
      dist_res = ((len_ff == '0) || !seen_ff) ? '0 : dist_sat;
   end

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      seen_in      = seen_ff;
      best_in      = best_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff;

      // hold off control items until the last text item leaves the row
      if (accept && is_text) begin
         drain_in = LW'(PAT_MAX);
      end else if (drain_ff != '0) begin
         drain_in = drain_ff - LW'(1);
      end

      // every text item marks the text as seen, even with an empty pattern;
      // track the minimum of the last row as its values arrive at the tail
      if (link[PAT_MAX].valid) begin
         seen_in = 1'b1;
         if (link[PAT_MAX].has_last && (!seen_ff || (last[PAT_MAX] < best_ff))) begin
            best_in = last[PAT_MAX];
         end
      end

      if (accept && (req_chan.opcode == OP_NEW_PATTERN)) begin
         len_in = '0;
         ovf_in = 1'b0;
      end
      if (accept && (req_chan.opcode == OP_APPEND)) begin
         if (append_ok) begin
            len_in = len_ff + LW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (clear_col) begin
         seen_in = 1'b0;
         best_in = '0;
      end

      // result slot: drop on take, load on finish
      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         best_ff      <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         seen_ff      <= seen_in;
         best_ff      <= best_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         dist_ff    <= dist_res;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.distance         = dist_ff;
   assign rsp_chan.pattern_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire
